FILE: rtl/tksel_pkg.sv
package tksel_pkg;

    localparam int KEY_W   = 31;
    localparam int SCORE_W = 31;
    localparam int TDATA_W = 64;
    localparam int PAD_W   = TDATA_W - KEY_W - SCORE_W;

    // one kept pair
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [KEY_W-1:0]   key;
    } t_entry;

endpackage

FILE: rtl/tksel_list.sv
module tksel_list #(
    parameter int KEEP_DEPTH = 10,
    parameter int CNT_W      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [tksel_pkg::KEY_W-1:0]   i_key,
    input  logic [tksel_pkg::SCORE_W-1:0] i_score,
    input  logic                         i_last,
    output tksel_pkg::t_entry            o_next_ent [KEEP_DEPTH],
    output logic [CNT_W-1:0]             o_next_cnt
);

    tksel_pkg::t_entry r_ent [KEEP_DEPTH];
    tksel_pkg::t_entry n_ent [KEEP_DEPTH];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [KEEP_DEPTH-1:0] w_ins;

    // new pair goes at or above slot k: empty slot, or it ranks strictly first
    genvar k;
    generate
        for (k = 0; k < KEEP_DEPTH; k++) begin : g_slot
            logic w_vld;
            logic w_before;
            assign w_vld    = CNT_W'(k) < r_cnt;
            assign w_before = (i_score > r_ent[k].score) ||
                              ((i_score == r_ent[k].score) && (i_key < r_ent[k].key));
            assign w_ins[k] = !w_vld || w_before;

            if (k == 0) begin : g_top
                always_comb begin
                    if (w_ins[k]) begin
                        n_ent[k] = '{score: i_score, key: i_key};
                    end else begin
                        n_ent[k] = r_ent[k];
                    end
                end
            end else begin : g_rest
                always_comb begin
                    if (w_ins[k] && !w_ins[k-1]) begin
                        n_ent[k] = '{score: i_score, key: i_key};
                    end else if (w_ins[k]) begin
                        n_ent[k] = r_ent[k-1];
                    end else begin
                        n_ent[k] = r_ent[k];
                    end
                end
            end
        end
    endgenerate

    assign n_cnt      = (r_cnt == CNT_W'(KEEP_DEPTH)) ? r_cnt : r_cnt + 1'b1;
    assign o_next_ent = n_ent;
    assign o_next_cnt = n_cnt;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_ent <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_valid) begin
            r_cnt <= i_last ? '0 : n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(KEEP_DEPTH))
        else $error("kept count beyond depth");

    a_cnt_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_last) |=>
            (r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == CNT_W'(KEEP_DEPTH)))
        else $error("kept count did not grow on a pair");

endmodule

FILE: rtl/tksel_drain.sv
module tksel_drain #(
    parameter int KEEP_DEPTH = 10,
    parameter int CNT_W      = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tksel_pkg::t_entry i_ent [KEEP_DEPTH],
    input  logic [CNT_W-1:0]  i_cnt,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic              o_tlast,
    output tksel_pkg::t_entry o_head,
    output logic              o_free
);

    tksel_pkg::t_entry r_ent [KEEP_DEPTH];
    logic [CNT_W-1:0]  r_cnt;
    logic              w_take;

    assign o_tvalid = r_cnt != '0;
    assign o_tlast  = r_cnt == CNT_W'(1);
    assign o_head   = r_ent[0];
    assign w_take   = o_tvalid && i_tready;
    // free once the last word of the previous set leaves
    assign o_free   = (r_cnt == '0) || (o_tlast && i_tready);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_ent;
        end else if (w_take) begin
            for (int j = 0; j < KEEP_DEPTH - 1; j++) begin
                r_ent[j] <= r_ent[j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
        end else if (w_take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_tready))
        else $error("drain bank loaded while words still pending");

    a_load_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> (r_cnt == $past(i_cnt)) && (r_cnt != '0))
        else $error("drain bank count wrong after load");

endmodule

FILE: rtl/top_k_score_selector.sv
// top-k score selector: takes one (key, score) pair per word on the slave
// side and keeps the best KEEP_DEPTH of them, ranked by score high to low and,
// on equal scores, by key low to high; a pair equal in key and score to kept
// ones goes after them, and a pair ranking below a full list is dropped.
// the word with tlast set closes the set: it is ranked like any other, then
// the whole kept list moves into a drain bank and leaves on the master side
// best first, one word per cycle while the master side is ready, with tlast
// on the final word, while the list starts empty for the next set. a pair
// passes through the input register and then the compare-and-shift list, so
// one pair is taken every cycle; the only stall is a closing word that meets
// a drain bank still holding words of the previous set, which waits until
// that set's final word is taken. a set of n pairs yields min(n, KEEP_DEPTH) words
module top_k_score_selector #(
    parameter int KEEP_DEPTH = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tksel_pkg::TDATA_W-1:0]  s_axis_tdata,  // item_key, item_score, zero pad
    input  logic                           s_axis_tlast,  // set_end
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tksel_pkg::TDATA_W-1:0]  m_axis_tdata,  // ranked_key, ranked_score, zero pad
    output logic                           m_axis_tlast   // final_rank
);

    localparam int CNT_W = $clog2(KEEP_DEPTH + 1);

    // input register
    logic                            r_in_valid;
    logic [tksel_pkg::KEY_W-1:0]     r_in_key;
    logic [tksel_pkg::SCORE_W-1:0]   r_in_score;
    logic                            r_in_last;

    logic                            w_advance;
    logic                            w_drain_free;
    tksel_pkg::t_entry               w_next_ent [KEEP_DEPTH];
    logic [CNT_W-1:0]                w_next_cnt;
    tksel_pkg::t_entry               w_head;

    // a closing word may only move on when the drain bank can take the list
    assign w_advance     = r_in_valid && (!r_in_last || w_drain_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_key   <= s_axis_tdata[tksel_pkg::KEY_W-1:0];
            r_in_score <= s_axis_tdata[tksel_pkg::KEY_W +: tksel_pkg::SCORE_W];
            r_in_last  <= s_axis_tlast;
        end
    end

    // kept list: parallel compare against every slot, insert by shift
    tksel_list #(
        .KEEP_DEPTH (KEEP_DEPTH),
        .CNT_W      (CNT_W)
    ) u_list (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_advance),
        .i_key      (r_in_key),
        .i_score    (r_in_score),
        .i_last     (r_in_last),
        .o_next_ent (w_next_ent),
        .o_next_cnt (w_next_cnt)
    );

    // drain bank: holds a closed set and shifts it out, head is the output word
    tksel_drain #(
        .KEEP_DEPTH (KEEP_DEPTH),
        .CNT_W      (CNT_W)
    ) u_drain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && r_in_last),
        .i_ent    (w_next_ent),
        .i_cnt    (w_next_cnt),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tlast  (m_axis_tlast),
        .o_head   (w_head),
        .o_free   (w_drain_free)
    );

    assign m_axis_tdata = {{tksel_pkg::PAD_W{1'b0}}, w_head.score, w_head.key};

endmodule
